/* hw/rtl/arpg_pkg.sv */
// ---------------------------------------------------------------------------
// arpg_pkg
// Types, constants and helpers shared by the region preemption guard.
// ---------------------------------------------------------------------------
package arpg_pkg;

  localparam int NUM_TASKS   = 16;
  localparam int COUNT_WIDTH = 16;

  localparam int ID_W   = 4;
  localparam int FUNC_W = 2;
  localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int ACT_W  = $clog2(NUM_TASKS + 1);

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [ACT_W-1:0]       act_t;

  localparam logic [FUNC_W-1:0] FUNC_OTHER  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENTER  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXIT   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] CFG_GUARD_ENABLED = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REGION_FORCE  = 1'b1;

  localparam count_t NEST_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_PEND,
    ST_OUT
  } state_t;

  // Map a task id onto a table slot
  function automatic slot_t slot_of(input logic [ID_W-1:0] id);
    slot_t s;
    s = '0;
    for (int i = 0; i < (1 << ID_W); i++) begin
      if (id == ID_W'(i)) begin
        s = SLOT_W'(i % NUM_TASKS);
      end
    end
    return s;
  endfunction

endpackage

/* hw/rtl/arpg_ram.sv */
// ---------------------------------------------------------------------------
// arpg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module arpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/atomic_region_preemption_guard.sv */
// ---------------------------------------------------------------------------
// atomic_region_preemption_guard
// Tracks atomic-region nesting per task and forces a task in the chosen
// region state to run first, with a one-time atomicity warning.
// ---------------------------------------------------------------------------
// One result item per event item. Nest counts live in a RAM with one write
// and one registered read port; each item is a read-modify-write sequence:
// ST_SLOT updates the task's count, ST_PEND (only with a pending enter) does
// a second read and write for the pending task, and ST_OUT registers the
// result; a disabled guard goes from accept straight to ST_OUT. The next item
// is taken once the result is registered. Per-entry valid bits make the count
// table read as zero after reset, so no clearing pass is needed.
module atomic_region_preemption_guard (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: task_id[3:0], read_only, selector_unset, skip_event,
  // task_runnable
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [arpg_pkg::S_TDATA_W-1:0]      s_tdata,
  // s_tuser: func
  input  logic [arpg_pkg::FUNC_W-1:0]         s_tuser,
  // m_tdata: force_first, atomicity_warning, exit_underflow, zero pad
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [arpg_pkg::M_TDATA_W-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [arpg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [arpg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  arpg_pkg::state_t state, state_next;

  logic guard_enabled, region_force;

  arpg_pkg::slot_t              in_slot;
  logic [arpg_pkg::FUNC_W-1:0]  in_func;
  logic in_ro, in_sel, in_skip, in_run;

  logic res_force, res_force_next;
  logic res_warn, res_warn_next;
  logic res_under, res_under_next;

  logic warned_once, warned_once_next;
  logic check_armed, check_armed_next;
  arpg_pkg::act_t  active_tasks, active_tasks_next;
  logic            pend_valid, pend_valid_next;
  arpg_pkg::slot_t pend_task, pend_task_next;
  arpg_pkg::count_t nest_fwd, nest_fwd_next;

  logic [arpg_pkg::NUM_TASKS-1:0] ent_valid;
  logic ent_vld;

  logic             ram_we;
  arpg_pkg::slot_t  ram_waddr, ram_raddr;
  arpg_pkg::count_t ram_wdata, ram_rdata;

  logic m_tvalid_next;
  logic [arpg_pkg::M_TDATA_W-1:0] m_tdata_next;

  arpg_pkg::count_t nest_s, nest_p, new_s;
  logic             arm;

  logic s_accept;

  assign s_tready = (state == arpg_pkg::ST_IDLE);
  assign s_accept = s_tvalid && s_tready;

  arpg_ram #(
    .WIDTH(arpg_pkg::COUNT_WIDTH),
    .DEPTH(arpg_pkg::NUM_TASKS)
  ) u_nest_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next        = state;
    res_force_next    = res_force;
    res_warn_next     = res_warn;
    res_under_next    = res_under;
    warned_once_next  = warned_once;
    check_armed_next  = check_armed;
    active_tasks_next = active_tasks;
    pend_valid_next   = pend_valid;
    pend_task_next    = pend_task;
    nest_fwd_next     = nest_fwd;
    ram_we            = 1'b0;
    ram_waddr         = in_slot;
    ram_wdata         = '0;
    ram_raddr         = arpg_pkg::slot_of(s_tdata[arpg_pkg::ID_W-1:0]);
    m_tvalid_next     = m_tvalid && !m_tready;
    m_tdata_next      = m_tdata;
    nest_s            = ent_vld ? ram_rdata : '0;
    nest_p            = (pend_task == in_slot) ? nest_fwd : nest_s;
    new_s             = nest_s;
    arm               = 1'b0;

    case (state)
      arpg_pkg::ST_IDLE: begin
        if (s_accept) begin
          if (guard_enabled) begin
            state_next = arpg_pkg::ST_SLOT;
          end else begin
            res_force_next = 1'b0;
            res_warn_next  = 1'b0;
            res_under_next = 1'b0;
            state_next     = arpg_pkg::ST_OUT;
          end
        end
      end

      arpg_pkg::ST_SLOT: begin
        res_warn_next  = 1'b0;
        res_under_next = 1'b0;
        if (check_armed && region_force && (active_tasks != '0) &&
            (nest_s == '0) && !warned_once) begin
          warned_once_next = 1'b1;
          res_warn_next    = 1'b1;
        end
        case (in_func)
          arpg_pkg::FUNC_EXIT: begin
            if (nest_s == '0) begin
              res_under_next = 1'b1;
            end else begin
              new_s  = nest_s - 1'b1;
              ram_we = 1'b1;
              if ((new_s == '0) && (active_tasks != '0)) begin
                active_tasks_next = active_tasks - 1'b1;
              end
              if (pend_valid && (pend_task == in_slot)) begin
                pend_valid_next = 1'b0;
              end
            end
          end
          arpg_pkg::FUNC_FINISH: begin
            if (nest_s != '0) begin
              new_s  = '0;
              ram_we = 1'b1;
              if (active_tasks != '0) begin
                active_tasks_next = active_tasks - 1'b1;
              end
            end
            if (pend_valid && (pend_task == in_slot)) begin
              pend_valid_next = 1'b0;
            end
          end
          default: begin
          end
        endcase
        ram_wdata = new_s;
        arm = !in_ro && in_sel && ((new_s != '0) == region_force) && in_run && !in_skip;
        check_armed_next = arm;
        res_force_next   = arm;
        nest_fwd_next    = new_s;
        ram_raddr        = pend_task;
        if (pend_valid_next) begin
          state_next = arpg_pkg::ST_PEND;
        end else begin
          if (in_func == arpg_pkg::FUNC_ENTER) begin
            pend_valid_next = 1'b1;
            pend_task_next  = in_slot;
          end
          state_next = arpg_pkg::ST_OUT;
        end
      end

      arpg_pkg::ST_PEND: begin
        if (nest_p == '0) begin
          active_tasks_next = active_tasks + 1'b1;
        end
        ram_we    = 1'b1;
        ram_waddr = pend_task;
        ram_wdata = (nest_p != arpg_pkg::NEST_MAX) ? nest_p + 1'b1 : nest_p;
        pend_valid_next = 1'b0;
        if (in_func == arpg_pkg::FUNC_ENTER) begin
          pend_valid_next = 1'b1;
          pend_task_next  = in_slot;
        end
        state_next = arpg_pkg::ST_OUT;
      end

      arpg_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {{(arpg_pkg::M_TDATA_W-3){1'b0}}, res_under, res_warn, res_force};
          state_next    = arpg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = arpg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= arpg_pkg::ST_IDLE;
      guard_enabled <= 1'b1;
      region_force  <= 1'b0;
      warned_once   <= 1'b0;
      check_armed   <= 1'b0;
      active_tasks  <= '0;
      pend_valid    <= 1'b0;
      pend_task     <= '0;
      ent_valid     <= '0;
      ent_vld       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state        <= state_next;
      warned_once  <= warned_once_next;
      check_armed  <= check_armed_next;
      active_tasks <= active_tasks_next;
      pend_valid   <= pend_valid_next;
      pend_task    <= pend_task_next;
      ent_vld      <= ent_valid[ram_raddr];
      m_tvalid     <= m_tvalid_next;
      if (ram_we) begin
        ent_valid[ram_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_addr)
          arpg_pkg::CFG_GUARD_ENABLED: guard_enabled <= cfg_wdata[0];
          arpg_pkg::CFG_REGION_FORCE:  region_force  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_force <= res_force_next;
    res_warn  <= res_warn_next;
    res_under <= res_under_next;
    nest_fwd  <= nest_fwd_next;
    m_tdata   <= m_tdata_next;
    if (s_accept) begin
      in_slot <= arpg_pkg::slot_of(s_tdata[arpg_pkg::ID_W-1:0]);
      in_func <= s_tuser;
      in_ro   <= s_tdata[4];
      in_sel  <= s_tdata[5];
      in_skip <= s_tdata[6];
      in_run  <= s_tdata[7];
    end
  end

  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    active_tasks <= arpg_pkg::ACT_W'(arpg_pkg::NUM_TASKS))
    else $error("active task count beyond task count");

  a_warn_sticky: assert property (@(posedge clk) disable iff (rst)
    warned_once |=> warned_once)
    else $error("warned flag cleared without reset");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == arpg_pkg::ST_SLOT || state == arpg_pkg::ST_PEND))
    else $error("count table written outside update phase");

  a_disabled_bypass: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !guard_enabled) |=> (state == arpg_pkg::ST_OUT && !res_force &&
                                      !res_warn && !res_under))
    else $error("disabled guard produced a non-zero result");

endmodule
